// ----- design/pstc_pkg.sv -----
package pstc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int PORT_SLOTS    = 10;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_IW       = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int USED_W        = $clog2(PORT_SLOTS + 1);
  localparam int PORT_DEPTH    = TABLE_ENTRIES * PORT_SLOTS;
  localparam int PADDR_W       = $clog2(PORT_DEPTH);
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] KIND_SYN    = 3'd1;
  localparam logic [2:0] KIND_SYNACK = 3'd2;
  localparam logic [2:0] KIND_FIN    = 3'd3;
  localparam logic [2:0] KIND_RST    = 3'd4;
  localparam logic [2:0] KIND_ICMP   = 3'd5;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [31:0]       key;
    logic [31:0]       c_syn;
    logic [31:0]       c_sa;
    logic [31:0]       c_fin;
    logic [31:0]       c_rst;
    logic [31:0]       c_from;
    logic [31:0]       c_to;
    logic [31:0]       c_icmp;
    logic [USED_W-1:0] used;
  } cnt_row_t;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] hits;
  } port_row_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] pos;
  } srch_res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic logic [PADDR_W-1:0] paddr(input logic [IDX_W-1:0] e,
                                               input logic [SLOT_IW-1:0] s);
    return PADDR_W'(e) * PADDR_W'(PORT_SLOTS) + PADDR_W'(s);
  endfunction

endpackage

// ----- design/pstc_key_search.sv -----
module pstc_key_search
  import pstc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             srch_start,
  input  logic [31:0]      srch_target,
  input  logic [CNT_W-1:0] srch_count,
  input  logic             kw_en,
  input  logic [IDX_W-1:0] kw_addr,
  input  logic [31:0]      kw_key,
  output srch_res_t        srch_res
);

  logic [31:0]      key_mem [TABLE_ENTRIES];
  logic [31:0]      key_q_r;
  logic [31:0]      tgt_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] issue_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_r;
  logic             busy_r;
  srch_res_t        res_r;
  logic             match;
  logic             more;

  assign match    = pend_r && (key_q_r == tgt_r);
  assign more     = issue_r < cnt_r;
  assign srch_res = res_r;

  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_key;
    end
    key_q_r <= key_mem[issue_r[IDX_W-1:0]];
  end

  // One key is read per cycle; the compare of the previous read overlaps the next read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pend_r     <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      if (srch_start) begin
        busy_r  <= 1'b1;
        pend_r  <= 1'b0;
        issue_r <= '0;
        tgt_r   <= srch_target;
        cnt_r   <= srch_count;
      end else if (busy_r) begin
        if (match) begin
          busy_r      <= 1'b0;
          pend_r      <= 1'b0;
          res_r.done  <= 1'b1;
          res_r.found <= 1'b1;
          res_r.pos   <= pend_idx_r;
        end else if (more) begin
          pend_r     <= 1'b1;
          pend_idx_r <= issue_r[IDX_W-1:0];
          issue_r    <= issue_r + CNT_W'(1);
        end else begin
          busy_r      <= 1'b0;
          pend_r      <= 1'b0;
          res_r.done  <= 1'b1;
          res_r.found <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    srch_start |=> !res_r.done) else $error("search done straight after start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done |-> !busy_r) else $error("search done while still busy");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.done && res_r.found) |-> (CNT_W'(res_r.pos) < cnt_r))
    else $error("found position beyond table fill");
`endif

endmodule

// ----- design/per_source_syn_counter_table.sv -----
// Per-source SYN counter table.
// Command channel: an item is taken when start is high and busy is low. Opcode 0 is a
// packet event, 1 reads one entry and one of its port slots, 2 clears the table.
// Result channel: every item gives one result, shown for a single cycle with
// out_valid high; the receiver cannot stall it, so it must take each transfer.
// Clear, unknown opcodes and a read beyond the fill count show their result in the cycle
// after they are taken; a read of a stored entry passes S_RD_RD and S_RD_OUT. A packet
// event walks the key memory one entry per cycle, once for the address of interest and,
// unless a fin, reset or icmp hit ends it early, once for the peer address; with a port
// given, a hit that does not end early also walks the port slots of its entry one per cycle.
// busy stays high until the result is shown; the next item may start in that cycle.
// Reset empties the table (fill count zero); memory contents are left as they are
// and are never read before being written.
module per_source_syn_counter_table
  import pstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_addr_interest,
  input  logic [31:0] in_addr_other,
  input  logic [2:0]  in_packet_kind,
  input  logic        in_port_valid,
  input  logic [15:0] in_dst_port,
  input  logic [9:0]  in_entry_index,
  input  logic [3:0]  in_port_slot,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_key_addr,
  output logic [31:0] out_syn_total,
  output logic [31:0] out_synack_total,
  output logic [31:0] out_fin_total,
  output logic [31:0] out_rst_total,
  output logic [31:0] out_tcp_from_total,
  output logic [31:0] out_tcp_to_total,
  output logic [31:0] out_icmp_total,
  output logic [3:0]  out_distinct_ports,
  output logic [15:0] out_slot_port,
  output logic [31:0] out_slot_hits
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_A_WAIT  = 13'b0000000000010,
    S_OWN_RD  = 13'b0000000000100,
    S_OWN_WR  = 13'b0000000001000,
    S_P_SRCH  = 13'b0000000010000,
    S_O_WAIT  = 13'b0000000100000,
    S_PEER_RD = 13'b0000001000000,
    S_PEER_WR = 13'b0000010000000,
    S_INS     = 13'b0000100000000,
    S_FIN_RD  = 13'b0001000000000,
    S_FIN_OUT = 13'b0010000000000,
    S_RD_RD   = 13'b0100000000000,
    S_RD_OUT  = 13'b1000000000000
  } state_t;

  cnt_row_t  cnt_mem  [TABLE_ENTRIES];
  port_row_t port_mem [PORT_DEPTH];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  cnt_row_t          out_row_r, out_row_nxt;
  logic [15:0]       out_sport_r, out_sport_nxt;
  logic [31:0]       out_shits_r, out_shits_nxt;

  logic [31:0]       a_r, o_r;
  logic [2:0]        kind_r;
  logic              pv_r;
  logic [15:0]       port_r;
  logic [IDX_W-1:0]  idx_r;
  logic [3:0]        slot_r;
  logic [IDX_W-1:0]  e_r, e_nxt;
  logic [IDX_W-1:0]  p_r, p_nxt;
  logic              hit_r, hit_nxt;
  cnt_row_t          row_r, row_nxt;
  logic [USED_W-1:0] pissue_r, pissue_nxt;
  logic [USED_W-1:0] ppidx_r, ppidx_nxt;
  logic              ppend_r, ppend_nxt;

  cnt_row_t          cnt_rd_r;
  port_row_t         pm_rd_r;
  logic [IDX_W-1:0]  cnt_ra;
  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_wa;
  cnt_row_t          cnt_wd;
  logic [PADDR_W-1:0] pm_ra;
  logic              pm_we;
  logic [PADDR_W-1:0] pm_wa;
  port_row_t         pm_wd;

  logic              srch_start;
  logic [31:0]       srch_target;
  logic              kw_en;
  srch_res_t         srch_res;

  logic              k_syn, k_sa, k_fin, k_rst, k_icmp, k_other;
  logic [SLOT_IW-1:0] rd_slot;
  logic              rd_slot_ok;
  logic              accept;
  cnt_row_t          upd;

  assign accept  = start && !busy;
  assign k_syn   = (kind_r == KIND_SYN) || (kind_r == KIND_SYNACK);
  assign k_sa    = kind_r == KIND_SYNACK;
  assign k_fin   = kind_r == KIND_FIN;
  assign k_rst   = kind_r == KIND_RST;
  assign k_icmp  = kind_r == KIND_ICMP;
  assign k_other = !k_icmp && !k_fin && !k_rst;

  assign rd_slot    = (32'(slot_r) < 32'(PORT_SLOTS)) ? SLOT_IW'(slot_r) : '0;
  assign rd_slot_ok = (32'(slot_r) < 32'(cnt_rd_r.used)) && (32'(slot_r) < 32'(PORT_SLOTS));

  pstc_key_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .srch_start (srch_start),
    .srch_target(srch_target),
    .srch_count (count_r),
    .kw_en      (kw_en),
    .kw_addr    (count_r[IDX_W-1:0]),
    .kw_key     (a_r),
    .srch_res   (srch_res)
  );

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      port_mem[pm_wa] <= pm_wd;
    end
    pm_rd_r <= port_mem[pm_ra];
  end

  always_comb begin
    cnt_ra = e_r;
    pm_ra  = paddr(e_r, pissue_r[SLOT_IW-1:0]);
    unique case (state_r)
      S_PEER_RD: cnt_ra = p_r;
      S_RD_RD: begin
        cnt_ra = idx_r;
        pm_ra  = paddr(idx_r, rd_slot);
      end
      default: ;
    endcase
  end

  always_comb begin
    upd = cnt_rd_r;
    if (k_syn) begin
      upd.c_syn = sat_inc(cnt_rd_r.c_syn);
      if (k_sa) begin
        upd.c_sa = sat_inc(cnt_rd_r.c_sa);
      end
    end else if (k_fin) begin
      upd.c_fin = sat_inc(cnt_rd_r.c_fin);
      upd.c_to  = sat_inc(cnt_rd_r.c_to);
    end else if (k_rst) begin
      upd.c_rst = sat_inc(cnt_rd_r.c_rst);
      upd.c_to  = sat_inc(cnt_rd_r.c_to);
    end
    if (k_other) begin
      upd.c_from = sat_inc(cnt_rd_r.c_from);
    end else begin
      upd.c_icmp = sat_inc(cnt_rd_r.c_icmp);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_row_nxt    = out_row_r;
    out_sport_nxt  = out_sport_r;
    out_shits_nxt  = out_shits_r;
    e_nxt          = e_r;
    p_nxt          = p_r;
    hit_nxt        = hit_r;
    row_nxt        = row_r;
    pissue_nxt     = pissue_r;
    ppidx_nxt      = ppidx_r;
    ppend_nxt      = ppend_r;
    srch_start     = 1'b0;
    srch_target    = o_r;
    kw_en          = 1'b0;
    cnt_we         = 1'b0;
    cnt_wa         = e_r;
    cnt_wd         = upd;
    pm_we          = 1'b0;
    pm_wa          = paddr(e_r, ppidx_r[SLOT_IW-1:0]);
    pm_wd          = '{port: port_r, hits: sat_inc(pm_rd_r.hits)};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_EVENT) begin
            srch_start  = 1'b1;
            srch_target = in_addr_interest;
            state_nxt   = S_A_WAIT;
          end else if (in_opcode == OP_READ &&
                       CNT_W'(in_entry_index) < count_r) begin
            state_nxt = S_RD_RD;
          end else begin
            if (in_opcode == OP_CLEAR) begin
              count_nxt = '0;
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_row_nxt    = '0;
            out_sport_nxt  = '0;
            out_shits_nxt  = '0;
          end
        end
      end
      S_A_WAIT: begin
        if (srch_res.done) begin
          hit_nxt = srch_res.found;
          e_nxt   = srch_res.pos;
          if (srch_res.found) begin
            state_nxt = S_OWN_RD;
          end else begin
            srch_start = 1'b1;
            state_nxt  = S_O_WAIT;
          end
        end
      end
      S_OWN_RD: state_nxt = S_OWN_WR;
      S_OWN_WR: begin
        cnt_we     = 1'b1;
        row_nxt    = upd;
        pissue_nxt = '0;
        ppend_nxt  = 1'b0;
        if (!k_other) begin
          state_nxt = S_FIN_RD;
        end else if (pv_r) begin
          state_nxt = S_P_SRCH;
        end else begin
          srch_start = 1'b1;
          state_nxt  = S_O_WAIT;
        end
      end
      S_P_SRCH: begin
        // Slot reads overlap compares of the previously read slot.
        if (ppend_r && pm_rd_r.port == port_r) begin
          pm_we      = 1'b1;
          srch_start = 1'b1;
          state_nxt  = S_O_WAIT;
        end else if (pissue_r < row_r.used) begin
          ppend_nxt  = 1'b1;
          ppidx_nxt  = pissue_r;
          pissue_nxt = pissue_r + USED_W'(1);
        end else begin
          if (32'(row_r.used) < 32'(PORT_SLOTS)) begin
            pm_we       = 1'b1;
            pm_wa       = paddr(e_r, row_r.used[SLOT_IW-1:0]);
            pm_wd       = '{port: port_r, hits: 32'd1};
            cnt_we      = 1'b1;
            cnt_wd      = row_r;
            cnt_wd.used = row_r.used + USED_W'(1);
          end
          srch_start = 1'b1;
          state_nxt  = S_O_WAIT;
        end
      end
      S_O_WAIT: begin
        if (srch_res.done) begin
          p_nxt = srch_res.pos;
          if (srch_res.found) begin
            state_nxt = S_PEER_RD;
          end else begin
            state_nxt = hit_r ? S_FIN_RD : S_INS;
          end
        end
      end
      S_PEER_RD: state_nxt = S_PEER_WR;
      S_PEER_WR: begin
        cnt_wa = p_r;
        cnt_wd = cnt_rd_r;
        if (!hit_r && (k_fin || k_rst)) begin
          cnt_wd.c_from = sat_inc(cnt_rd_r.c_from);
        end else if (!k_icmp) begin
          cnt_wd.c_to = sat_inc(cnt_rd_r.c_to);
        end
        cnt_we    = 1'b1;
        state_nxt = hit_r ? S_FIN_RD : S_INS;
      end
      S_INS: begin
        out_valid_nxt = 1'b1;
        out_sport_nxt = '0;
        out_shits_nxt = '0;
        state_nxt     = S_IDLE;
        if (32'(count_r) >= 32'(TABLE_ENTRIES)) begin
          out_status_nxt  = ST_FULL;
          out_row_nxt     = '0;
          out_row_nxt.key = a_r;
        end else begin
          cnt_wd     = '0;
          cnt_wd.key = a_r;
          if (k_syn) begin
            cnt_wd.c_syn  = 32'd1;
            cnt_wd.c_from = 32'd1;
            cnt_wd.c_sa   = k_sa ? 32'd1 : 32'd0;
            if (pv_r) begin
              cnt_wd.used = USED_W'(1);
              pm_we       = 1'b1;
              pm_wa       = paddr(count_r[IDX_W-1:0], '0);
              pm_wd       = '{port: port_r, hits: 32'd1};
            end
          end else if (k_fin) begin
            cnt_wd.c_fin = 32'd1;
            cnt_wd.c_to  = 32'd1;
          end else if (k_rst) begin
            cnt_wd.c_rst = 32'd1;
            cnt_wd.c_to  = 32'd1;
          end
          cnt_we         = 1'b1;
          cnt_wa         = count_r[IDX_W-1:0];
          kw_en          = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          out_status_nxt = ST_INS;
          out_row_nxt    = cnt_wd;
        end
      end
      S_FIN_RD: state_nxt = S_FIN_OUT;
      S_FIN_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_HIT;
        out_row_nxt    = cnt_rd_r;
        out_sport_nxt  = '0;
        out_shits_nxt  = '0;
        state_nxt      = S_IDLE;
      end
      S_RD_RD: state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_READ;
        out_row_nxt    = cnt_rd_r;
        out_sport_nxt  = rd_slot_ok ? pm_rd_r.port : 16'd0;
        out_shits_nxt  = rd_slot_ok ? pm_rd_r.hits : 32'd0;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= in_addr_interest;
      o_r    <= in_addr_other;
      kind_r <= in_packet_kind;
      pv_r   <= in_port_valid;
      port_r <= in_dst_port;
      idx_r  <= in_entry_index;
      slot_r <= in_port_slot;
    end
    out_status_r <= out_status_nxt;
    out_row_r    <= out_row_nxt;
    out_sport_r  <= out_sport_nxt;
    out_shits_r  <= out_shits_nxt;
    e_r          <= e_nxt;
    p_r          <= p_nxt;
    hit_r        <= hit_nxt;
    row_r        <= row_nxt;
    pissue_r     <= pissue_nxt;
    ppidx_r      <= ppidx_nxt;
    ppend_r      <= ppend_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_key_addr       = out_row_r.key;
  assign out_syn_total      = out_row_r.c_syn;
  assign out_synack_total   = out_row_r.c_sa;
  assign out_fin_total      = out_row_r.c_fin;
  assign out_rst_total      = out_row_r.c_rst;
  assign out_tcp_from_total = out_row_r.c_from;
  assign out_tcp_to_total   = out_row_r.c_to;
  assign out_icmp_total     = out_row_r.c_icmp;
  assign out_distinct_ports = 4'(out_row_r.used);
  assign out_slot_port      = out_sport_r;
  assign out_slot_hits      = out_shits_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(TABLE_ENTRIES)) else $error("table fill beyond capacity");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_CLEAR) |=> (out_valid && out_status == ST_EMPTY && count_r == '0))
    else $error("clear did not empty the table");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INS) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert without fill count step");
`endif

endmodule
